### design/sprps_pkg.sv
package sprps_pkg;

  localparam int MODE_W = 3;
  localparam int KIND_W = 2;
  localparam int ACT_W  = 2;
  localparam int DEV_W  = 7;
  localparam int ADDR_W = 16;
  localparam int CNT_W  = 10;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_KEY_REC = 3'd1;
  localparam logic [MODE_W-1:0] MODE_KEY_PB  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_KEY_CLR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_DUTY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REQ  = 2'd2;

  localparam logic [ACT_W-1:0] ACT_IDLE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REC  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PB   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

  localparam logic [DEV_W-1:0]  RST_DEVICE = 7'h50;
  localparam logic [ADDR_W-1:0] RST_START  = 16'h0050;
  localparam logic [CNT_W-1:0]  RST_LIMIT  = 10'd1000;

  typedef struct packed {
    logic              exec;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic              last;
  } ctl_cmd_t;

  typedef struct packed {
    logic flush;
    logic duty;
    logic pg_end;
    logic out_free;
    logic fl_end;
  } ctl_st_t;

  function automatic logic [ACT_W-1:0] act_code(input logic rec, input logic pb,
                                                input logic clr);
    logic [ACT_W-1:0] c;
    if (rec) c = ACT_REC;
    else if (pb) c = ACT_PB;
    else if (clr) c = ACT_CLR;
    else c = ACT_IDLE;
    return c;
  endfunction

endpackage

### design/sprps_ram.sv
module sprps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/sprps_ctrl.sv
module sprps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  sprps_pkg::ctl_st_t  st,
  output sprps_pkg::ctl_cmd_t cmd
);
  import sprps_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DUTY  = 3'd1;
  localparam logic [2:0] S_DUTYE = 3'd2;
  localparam logic [2:0] S_REQ   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.exec  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.kind  = KIND_DUTY;
    cmd.last  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.exec = 1'b1;
          if (st.flush) state_nxt = S_FLUSH;
          else if (st.pg_end) state_nxt = S_DUTYE;
          else if (st.duty) state_nxt = S_DUTY;
        end
      end
      S_DUTY: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DUTYE: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_REQ;
        end
      end
      S_REQ: begin
        cmd.kind = KIND_REQ;
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        cmd.kind = KIND_WR;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = st.fl_end;
          if (st.fl_end) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/sprps_dp.sv
module sprps_dp #(
  parameter int PAGE_BYTES = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [sprps_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [sprps_pkg::MODE_W-1:0]         in_tuser,
  input  logic                                 cfg_we,
  input  logic [sprps_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [sprps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  sprps_pkg::ctl_cmd_t                  cmd,
  output sprps_pkg::ctl_st_t                   st,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sprps_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [sprps_pkg::KIND_W-1:0]         out_tuser,
  output logic                                 out_tlast
);
  import sprps_pkg::*;

  localparam int IDX_W  = $clog2(PAGE_BYTES);
  localparam int FILL_W = $clog2(PAGE_BYTES + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(PAGE_BYTES - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] PAGE_STEP = ADDR_W'(PAGE_BYTES);

  logic [DEV_W-1:0]  dev_r;
  logic [ADDR_W-1:0] start_r;
  logic [CNT_W-1:0]  limit_r;

  logic              rec_on_r, rec_on_nxt;
  logic              pb_on_r, pb_on_nxt;
  logic              clr_on_r, clr_on_nxt;
  logic [IDX_W-1:0]  bi_r, bi_nxt;
  logic [CNT_W-1:0]  pc_r, pc_nxt, pc_inc;
  logic [ADDR_W-1:0] addr_r, addr_nxt, addr_adv;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_W-1:0] snap_r;
  logic [ACT_W-1:0]  act_r;

  logic [PAGE_BYTES-1:0] rec_vld_r;
  logic [PAGE_BYTES-1:0] pb_vld_r;
  logic                  rec_vq_r;
  logic                  pb_vq_r;

  logic              out_vld_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [DEV_W-1:0]  out_dev_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_last_r;
  logic [ACT_W-1:0]  out_act_r;

  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] sample;
  logic [BYTE_W-1:0] rbyte;
  logic              tick, tick_rec, tick_pb, tick_clr, page_full, fill_ok;

  logic              rec_we, pb_we;
  logic [IDX_W-1:0]  pb_waddr;
  logic [BYTE_W-1:0] rec_wdata, pb_wdata;
  logic [BYTE_W-1:0] rec_dout, pb_dout, rec_byte, pb_byte;
  logic              out_free;

  assign mode   = in_tuser;
  assign sample = in_tdata[7:0];
  assign rbyte  = in_tdata[15:8];

  assign tick      = (mode == MODE_TICK);
  assign tick_rec  = tick & rec_on_r;
  assign tick_pb   = tick & !rec_on_r & pb_on_r;
  assign tick_clr  = tick & !rec_on_r & !pb_on_r & clr_on_r;
  assign page_full = (bi_r == LAST_IDX);
  assign fill_ok   = (fill_r < FILL_FULL);
  assign out_free  = !out_vld_r | out_tready;

  assign st.flush    = (tick_rec | tick_clr) & page_full;
  assign st.duty     = tick_pb;
  assign st.pg_end   = tick_pb & page_full;
  assign st.out_free = out_free;
  assign st.fl_end   = (rd_ptr_r == LAST_IDX);

  // step update
  always_comb begin
    rec_on_nxt = rec_on_r;
    pb_on_nxt  = pb_on_r;
    clr_on_nxt = clr_on_r;
    bi_nxt     = bi_r;
    pc_nxt     = pc_r;
    addr_nxt   = addr_r;
    fill_nxt   = fill_r;
    pc_inc     = page_full ? pc_r + 1'b1 : pc_r;
    addr_adv   = page_full ? addr_r + PAGE_STEP : addr_r;
    if (cmd.exec) begin
      case (mode)
        MODE_TICK: begin
          if (tick_rec | tick_clr) begin
            bi_nxt = page_full ? '0 : bi_r + 1'b1;
            if (pc_inc == limit_r) begin
              rec_on_nxt = rec_on_r & !tick_rec;
              clr_on_nxt = clr_on_r & !tick_clr;
              pc_nxt     = '0;
              addr_nxt   = start_r;
            end else begin
              pc_nxt   = pc_inc;
              addr_nxt = addr_adv;
            end
          end else if (tick_pb) begin
            if (page_full) begin
              bi_nxt   = '0;
              fill_nxt = '0;
              addr_nxt = addr_adv;
              pc_nxt   = pc_inc;
            end else begin
              bi_nxt = bi_r + 1'b1;
              if (pc_r == limit_r) begin
                pb_on_nxt = 1'b0;
                pc_nxt    = '0;
                addr_nxt  = start_r;
              end
            end
          end
        end
        MODE_KEY_REC: begin
          rec_on_nxt = 1'b1;
          pb_on_nxt  = 1'b0;
        end
        MODE_KEY_PB: begin
          rec_on_nxt = 1'b0;
          pb_on_nxt  = 1'b1;
        end
        MODE_KEY_CLR: begin
          rec_on_nxt = 1'b0;
          pb_on_nxt  = 1'b0;
          clr_on_nxt = 1'b1;
        end
        MODE_READ: begin
          if (fill_ok) fill_nxt = fill_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // page buffers
  assign rec_we    = cmd.exec & (tick_rec | tick_clr);
  assign rec_wdata = tick_rec ? sample : '0;
  assign pb_we     = cmd.exec & (tick_clr | ((mode == MODE_READ) & fill_ok));
  assign pb_waddr  = tick_clr ? bi_r : fill_r[IDX_W-1:0];
  assign pb_wdata  = tick_clr ? '0 : rbyte;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    if (cmd.exec) rd_ptr_nxt = '0;
    else if (cmd.emit && cmd.kind == KIND_WR) rd_ptr_nxt = st.fl_end ? '0 : rd_ptr_r + 1'b1;
  end

  sprps_ram #(.WIDTH(BYTE_W), .DEPTH(PAGE_BYTES)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (bi_r),
    .wdata (rec_wdata),
    .re    (1'b1),
    .raddr (rd_ptr_nxt),
    .rdata (rec_dout)
  );

  sprps_ram #(.WIDTH(BYTE_W), .DEPTH(PAGE_BYTES)) u_pb_ram (
    .clk   (clk),
    .we    (pb_we),
    .waddr (pb_waddr),
    .wdata (pb_wdata),
    .re    (cmd.exec),
    .raddr (bi_r),
    .rdata (pb_dout)
  );

  // never-written entries read as zero
  assign rec_byte = rec_vq_r ? rec_dout : '0;
  assign pb_byte  = pb_vq_r ? pb_dout : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r     <= RST_DEVICE;
      start_r   <= RST_START;
      limit_r   <= RST_LIMIT;
      rec_on_r  <= 1'b0;
      pb_on_r   <= 1'b0;
      clr_on_r  <= 1'b0;
      bi_r      <= '0;
      pc_r      <= '0;
      addr_r    <= RST_START;
      fill_r    <= '0;
      rd_ptr_r  <= '0;
      rec_vld_r <= '0;
      pb_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_DEVICE: dev_r   <= cfg_wdata[DEV_W-1:0];
          REG_START:  start_r <= cfg_wdata[ADDR_W-1:0];
          REG_LIMIT:  limit_r <= cfg_wdata[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      rec_on_r <= rec_on_nxt;
      pb_on_r  <= pb_on_nxt;
      clr_on_r <= clr_on_nxt;
      bi_r     <= bi_nxt;
      pc_r     <= pc_nxt;
      addr_r   <= addr_nxt;
      fill_r   <= fill_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      if (rec_we) rec_vld_r[bi_r] <= 1'b1;
      if (pb_we) pb_vld_r[pb_waddr] <= 1'b1;
      if (cmd.emit) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rec_vq_r <= rec_vld_r[rd_ptr_nxt];
    if (cmd.exec) begin
      pb_vq_r <= pb_vld_r[bi_r];
      snap_r  <= addr_r;
      act_r   <= act_code(rec_on_nxt, pb_on_nxt, clr_on_nxt);
    end
    if (cmd.emit) begin
      out_kind_r <= cmd.kind;
      out_last_r <= cmd.last;
      out_act_r  <= act_r;
      case (cmd.kind)
        KIND_WR: begin
          out_dev_r  <= dev_r;
          out_addr_r <= snap_r;
          out_data_r <= rec_byte;
        end
        KIND_REQ: begin
          out_dev_r  <= dev_r;
          out_addr_r <= snap_r;
          out_data_r <= '0;
        end
        default: begin
          out_dev_r  <= '0;
          out_addr_r <= '0;
          out_data_r <= pb_byte;
        end
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'b0, out_act_r, out_data_r, out_addr_r, out_dev_r};

endmodule

### design/sample_page_record_playback_sequencer.sv
// Channel  Ports                       Contents
// in       in_tvalid/tready/tdata/tuser tuser: mode; tdata: sample, read_byte
// out      out_tvalid/tready/tdata/tuser/tlast  tuser: kind; tdata: see port
// cfg      cfg_we/cfg_addr/cfg_wdata   0 device_address, 1 start_address, 2 page_limit
//
// Keys, read bytes and idle ticks finish on acceptance; a playback tick
// then emits its duty byte (and the read request at a page end); a tick
// that fills a page writes it out, one byte a cycle while the output is
// free, from the single-read page RAM. Reset is synchronous; page buffers
// read as zero from reset through per-entry valid flags, no clearing pass.
module sample_page_record_playback_sequencer #(
  parameter int PAGE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample[7:0], read_byte[15:8]
  input  logic [2:0]  in_tuser,   // mode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // bus_device[6:0], mem_address[22:7],
                                  // data_byte[30:23], active_mode[32:31], zero[39:33]
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import sprps_pkg::*;

  ctl_cmd_t cmd;
  ctl_st_t  st;

  sprps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  sprps_dp #(.PAGE_BYTES(PAGE_BYTES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (st.flush || st.duty) |=> !in_tready)
    else $error("request with results accepted but input still ready");

  a_req_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_REQ |-> out_tlast)
    else $error("page read request not marked last");

  a_duty_no_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DUTY |-> out_tdata[22:0] == 23'd0)
    else $error("duty result carries bus fields");

  a_no_emit_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !cmd.emit)
    else $error("result loaded in the accept cycle");
`endif

endmodule

### sim/tb_sample_page_record_playback_sequencer.sv
module tb_sample_page_record_playback_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import sprps_pkg::*;

  localparam int PAGE      = 32;
  localparam int PIDX_W    = $clog2(PAGE);
  localparam int MAX_LINES = 40;

  // mode codes the block has no use for
  localparam logic [MODE_W-1:0] MODE_BAD_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_BAD_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_BAD_HI = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DEV_W-1:0]  dev;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [ACT_W-1:0]  act;
  } page_res_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] smp;
    logic [BYTE_W-1:0] rdb;
    logic              typed;
    logic              has_res;
    page_res_t         res;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]     in_tuser = MODE_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = REG_DEVICE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic quiet = 1'b0;
  int   stall_left = 0;
  int   mismatches = 0;
  int   results_seen = 0;
  int   live_items = 0;
  logic page_req_seen = 1'b0;

  // sequencer state as predicted
  logic [DEV_W-1:0]  dev_reg = RST_DEVICE;
  logic [ADDR_W-1:0] start_reg = RST_START;
  logic [CNT_W-1:0]  limit_reg = RST_LIMIT;
  logic              rec_on = 1'b0;
  logic              pb_on = 1'b0;
  logic              clr_on = 1'b0;
  logic [5:0]        byte_pos = '0;
  logic [CNT_W-1:0]  pages_done = '0;
  logic [ADDR_W-1:0] cur_addr = RST_START;
  logic [BYTE_W-1:0] rec_buf [PAGE];
  logic [BYTE_W-1:0] pb_buf [PAGE];
  logic [5:0]        fill_pos = '0;

  page_res_t   step_res[$];
  page_res_t   due_results[$];
  script_row_t script_q[$];
  logic [MODE_W-1:0] key_codes [3] = '{MODE_KEY_REC, MODE_KEY_PB, MODE_KEY_CLR};

  sample_page_record_playback_sequencer #(
    .PAGE_BYTES(PAGE)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [BYTE_W-1:0] rnd_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic script_row_t free_row(input logic [MODE_W-1:0] m,
                                           input logic [BYTE_W-1:0] s,
                                           input logic [BYTE_W-1:0] rb);
    script_row_t t;
    t = '0;
    t.mode = m;
    t.smp = s;
    t.rdb = rb;
    return t;
  endfunction

  function automatic script_row_t pinned_row(input logic [MODE_W-1:0] m,
                                             input logic [BYTE_W-1:0] s,
                                             input logic [BYTE_W-1:0] rb,
                                             input page_res_t r);
    script_row_t t;
    t = free_row(m, s, rb);
    t.typed = 1'b1;
    t.has_res = 1'b1;
    t.res = r;
    return t;
  endfunction

  function automatic script_row_t silent_row(input logic [MODE_W-1:0] m,
                                             input logic [BYTE_W-1:0] s,
                                             input logic [BYTE_W-1:0] rb);
    script_row_t t;
    t = free_row(m, s, rb);
    t.typed = 1'b1;
    return t;
  endfunction

  function automatic page_res_t duty_of(input logic [BYTE_W-1:0] b);
    page_res_t r;
    r = '0;
    r.kind = KIND_DUTY;
    r.data = b;
    r.last = 1'b1;
    r.act = ACT_PB;
    return r;
  endfunction

  function automatic logic [ACT_W-1:0] running_mode();
    if (rec_on) return ACT_REC;
    if (pb_on) return ACT_PB;
    if (clr_on) return ACT_CLR;
    return ACT_IDLE;
  endfunction

  task automatic emit(input logic [KIND_W-1:0] k, input logic [DEV_W-1:0] d,
                      input logic [ADDR_W-1:0] a, input logic [BYTE_W-1:0] b);
    page_res_t r;
    r = '0;
    r.kind = k;
    r.dev = d;
    r.addr = a;
    r.data = b;
    step_res.push_back(r);
  endtask

  task automatic write_page();
    for (int k = 0; k < PAGE; k++) emit(KIND_WR, dev_reg, cur_addr, rec_buf[k]);
    cur_addr += ADDR_W'(PAGE);
    byte_pos = '0;
    pages_done += 1'b1;
  endtask

  task automatic end_run();
    pages_done = '0;
    cur_addr = start_reg;
  endtask

  task automatic sequence_step(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] s,
                               input logic [BYTE_W-1:0] rb);
    logic [5:0] bi;
    page_res_t r;
    step_res.delete();
    page_req_seen = 1'b0;
    bi = (byte_pos >= PAGE) ? 6'd0 : byte_pos;
    if (m <= MODE_READ && !(m == MODE_TICK && !rec_on && !pb_on && !clr_on)) live_items++;
    case (m)
      MODE_TICK: begin
        if (rec_on) begin
          rec_buf[bi[PIDX_W-1:0]] = s;
          byte_pos = bi + 6'd1;
          if (byte_pos == PAGE) write_page();
          if (pages_done == limit_reg) begin
            rec_on = 1'b0;
            end_run();
          end
        end else if (pb_on) begin
          emit(KIND_DUTY, '0, '0, pb_buf[bi[PIDX_W-1:0]]);
          byte_pos = bi + 6'd1;
          if (byte_pos == PAGE) begin
            emit(KIND_REQ, dev_reg, cur_addr, '0);
            page_req_seen = 1'b1;
            fill_pos = '0;
            cur_addr += ADDR_W'(PAGE);
            byte_pos = '0;
            pages_done += 1'b1;
          end else if (pages_done == limit_reg) begin
            pb_on = 1'b0;
            end_run();
          end
        end else if (clr_on) begin
          rec_buf[bi[PIDX_W-1:0]] = '0;
          pb_buf[bi[PIDX_W-1:0]] = '0;
          byte_pos = bi + 6'd1;
          if (byte_pos == PAGE) write_page();
          if (pages_done == limit_reg) begin
            clr_on = 1'b0;
            end_run();
          end
        end
      end
      MODE_KEY_REC: begin
        rec_on = 1'b1;
        pb_on = 1'b0;
      end
      MODE_KEY_PB: begin
        rec_on = 1'b0;
        pb_on = 1'b1;
      end
      MODE_KEY_CLR: begin
        rec_on = 1'b0;
        pb_on = 1'b0;
        clr_on = 1'b1;
      end
      MODE_READ: begin
        if (fill_pos < PAGE) begin
          pb_buf[fill_pos[PIDX_W-1:0]] = rb;
          fill_pos += 6'd1;
        end
      end
      default: ;
    endcase
    for (int k = 0; k < step_res.size(); k++) begin
      r = step_res[k];
      r.last = (k == step_res.size() - 1);
      r.act = running_mode();
      step_res[k] = r;
    end
  endtask

  task automatic send_item(input script_row_t row);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= row.mode;
    in_tdata <= {row.rdb, row.smp};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    sequence_step(row.mode, row.smp, row.rdb);
    if (row.typed) begin
      if (row.has_res) due_results.push_back(row.res);
    end else begin
      foreach (step_res[k]) due_results.push_back(step_res[k]);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (PAGE + 8) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [DEV_W-1:0] dev, input logic [ADDR_W-1:0] start,
                                input logic [CNT_W-1:0] limit);
    cfg_we <= 1'b1;
    cfg_addr <= REG_DEVICE;
    cfg_wdata <= CFG_DATA_W'(dev);
    @(posedge clk);
    cfg_addr <= REG_START;
    cfg_wdata <= start;
    @(posedge clk);
    cfg_addr <= REG_LIMIT;
    cfg_wdata <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
    dev_reg = dev;
    start_reg = start;
    limit_reg = limit;
  endtask

  // mostly key-then-ticks runs, refilled after each page read request
  task automatic random_phase(input int target);
    int stop_at;
    int pick;
    stop_at = live_items + target;
    while (live_items < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_item(free_row(key_codes[2'($urandom_range(0, 2))], rnd_byte(), rnd_byte()));
        repeat ($urandom_range(4, 40)) begin
          send_item(free_row(MODE_TICK, rnd_byte(), rnd_byte()));
          if (page_req_seen) begin
            repeat ($urandom_range(30, 34)) begin
              send_item(free_row(MODE_READ, rnd_byte(), rnd_byte()));
            end
          end
        end
      end else if (pick < 9) begin
        repeat ($urandom_range(1, 36)) send_item(free_row(MODE_READ, rnd_byte(), rnd_byte()));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(free_row(MODE_W'($urandom_range(0, 7)), rnd_byte(), rnd_byte()));
        end
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    mismatches++;
    if (mismatches <= MAX_LINES) begin
      $display("%0t: result %0d %s: got 0x%0h, want 0x%0h", $time, results_seen, what,
               got, want);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && rst_n && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    page_res_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      results_seen++;
      if (due_results.size() == 0) begin
        flag_mismatch("arrived with nothing due, kind", out_tuser, 0);
      end else begin
        want = due_results.pop_front();
        if (out_tuser !== want.kind) flag_mismatch("kind", out_tuser, want.kind);
        if (out_tdata[6:0] !== want.dev) flag_mismatch("bus_device", out_tdata[6:0], want.dev);
        if (out_tdata[22:7] !== want.addr) begin
          flag_mismatch("mem_address", out_tdata[22:7], want.addr);
        end
        if (out_tdata[30:23] !== want.data) begin
          flag_mismatch("data_byte", out_tdata[30:23], want.data);
        end
        if (out_tlast !== want.last) flag_mismatch("last", out_tlast, want.last);
        if (out_tdata[32:31] !== want.act) begin
          flag_mismatch("active_mode", out_tdata[32:31], want.act);
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < PAGE; k++) begin
      rec_buf[k] = '0;
      pb_buf[k] = '0;
    end

    script_q.push_back(silent_row(MODE_TICK, 8'hFF, 8'hFF));
    script_q.push_back(silent_row(MODE_BAD_LO, 8'h00, 8'h00));
    script_q.push_back(silent_row(MODE_BAD_HI, 8'hFF, 8'hFF));
    script_q.push_back(silent_row(MODE_READ, 8'h00, 8'hFF));
    script_q.push_back(silent_row(MODE_READ, 8'hFF, 8'h00));
    script_q.push_back(silent_row(MODE_READ, 8'h00, 8'hA5));
    script_q.push_back(silent_row(MODE_KEY_PB, 8'h00, 8'h00));
    script_q.push_back(pinned_row(MODE_TICK, 8'h00, 8'h00, duty_of(8'hFF)));
    script_q.push_back(pinned_row(MODE_TICK, 8'hFF, 8'hFF, duty_of(8'h00)));
    script_q.push_back(pinned_row(MODE_TICK, 8'h00, 8'h00, duty_of(8'hA5)));
    script_q.push_back(pinned_row(MODE_TICK, 8'h3C, 8'hC3, duty_of(8'h00)));
    script_q.push_back(silent_row(MODE_KEY_REC, 8'h00, 8'h00));
    script_q.push_back(silent_row(MODE_TICK, 8'hFF, 8'h00));
    script_q.push_back(silent_row(MODE_TICK, 8'h00, 8'hFF));
    script_q.push_back(silent_row(MODE_KEY_CLR, 8'h00, 8'h00));
    script_q.push_back(free_row(MODE_TICK, 8'h55, 8'hAA));
    script_q.push_back(free_row(MODE_KEY_REC, 8'h00, 8'h00));
    script_q.push_back(free_row(MODE_TICK, 8'h80, 8'h01));
    script_q.push_back(free_row(MODE_KEY_PB, 8'h00, 8'h00));
    script_q.push_back(free_row(MODE_TICK, 8'h01, 8'h80));
    script_q.push_back(silent_row(MODE_BAD_MID, 8'h7F, 8'hFE));
    script_q.push_back(free_row(MODE_READ, 8'h00, 8'h5A));
    script_q.push_back(free_row(MODE_TICK, 8'hAA, 8'h55));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script_q[i]) send_item(script_q[i]);
    settle();

    apply_settings(7'h7F, 16'hFFE0, 10'd1);
    random_phase(60);
    settle();

    apply_settings(7'h00, 16'h0000, 10'd2);
    random_phase(30);
    settle();
    random_phase(30);
    settle();

    apply_settings(DEV_W'($urandom_range(1, 126)), 16'hFFFF, 10'd3);
    random_phase(60);
    settle();

    quiet <= 1'b1;
    apply_settings(DEV_W'($urandom_range(0, 127)), ADDR_W'($urandom_range(0, 65535)),
                   10'd1023);
    random_phase(60);
    settle();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### sample_page_record_playback_sequencer.f
design/sprps_pkg.sv
design/sprps_ram.sv
design/sprps_ctrl.sv
design/sprps_dp.sv
design/sample_page_record_playback_sequencer.sv
sim/tb_sample_page_record_playback_sequencer.sv
